/* rtl/pdlr_pkg.sv */
// Shared constants and widths for the downmix and linear resampler block.
package pdlr_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int CHAN_W       = 4;
  localparam int STEP_W       = 29;
  localparam int MAX_CHANNELS = 8;
  localparam int FRAC_BITS    = 24;
  localparam int MAX_RESULTS  = 64;

  localparam int CNT_W      = $clog2(MAX_CHANNELS + 1);
  localparam int IDX_W      = $clog2(MAX_CHANNELS);
  localparam int SUM_W      = SAMPLE_W + $clog2(MAX_CHANNELS);
  localparam int PHASE_W    = STEP_W + 1;
  localparam int RES_W      = $clog2(MAX_RESULTS + 1);
  localparam int CFG_DATA_W = STEP_W;
  localparam int REG_IDX_W  = 2;
  localparam int DIV_CNT_W  = $clog2(SUM_W + 1);

  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << FRAC_BITS;
  localparam logic [STEP_W-1:0]  STEP_ONE  = STEP_W'(1) << FRAC_BITS;

  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_RESAMPLE_ENABLE = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_PHASE_STEP      = 2'd2;

endpackage

/* rtl/pdlr_in_if.sv */
// Input channel: one interleaved PCM sample per item.
interface pdlr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pdlr_pkg::SAMPLE_W-1:0] sample_in;
  logic                                  chunk_end;

  modport source (output valid, output sample_in, output chunk_end, input ready);
  modport sink   (input valid, input sample_in, input chunk_end, output ready);
endinterface

/* rtl/pdlr_out_if.sv */
// Output channel: one mono sample at the destination rate per item.
interface pdlr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [pdlr_pkg::SAMPLE_W-1:0] sample_out;
  logic                                  last_of_run;

  modport source (output valid, output sample_out, output last_of_run, input ready);
  modport sink   (input valid, input sample_out, input last_of_run, output ready);
endinterface

/* rtl/pcm_downmix_linear_resampler.sv */
// Top level: mono downmix, frame averaging and linear-interpolation resampler.
//
//   channel      dir   handshake      payload
//   in_stream    in    valid/ready    sample_in (s16), chunk_end
//   out_stream   out   valid/ready    sample_out (s16), last_of_run
//   wr_*         in    wr_en only     wr_index (2b), wr_data (29b)
//
// A non-closing sample leaves the input ready for the next one. A closing one holds the input
// through S_DIV in the bit-serial divider (load, then one quotient bit per cycle for 19 bits)
// and S_DISPATCH; pass-through adds the S_PASS hand-off. Each interpolated result goes through
// the loop test, the shared interpolation unit and the hand-off; S_FINISH then wraps phase.
// Synchronous active-high reset clears the frame, phase and priming state at once.
// A waiting result lets the next sample in; a stalled output holds the sequencer only
// when it has a further result to hand over.
module pcm_downmix_linear_resampler (
  input  logic                               clk,
  input  logic                               rst,
  pdlr_in_if.sink                            in_stream,
  pdlr_out_if.source                         out_stream,
  input  logic                               wr_en,
  input  logic [pdlr_pkg::REG_IDX_W-1:0]     wr_index,
  input  logic [pdlr_pkg::CFG_DATA_W-1:0]    wr_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_DISPATCH,
    S_PASS,
    S_CHECK,
    S_INTERP,
    S_EMIT,
    S_FINISH
  } state_t;

  // configuration registers
  logic [pdlr_pkg::CHAN_W-1:0]          channel_count;
  logic                                 resample_enable;
  logic [pdlr_pkg::STEP_W-1:0]          phase_step;

  // block state
  state_t                               state;
  logic signed [pdlr_pkg::SUM_W-1:0]    frame_sum;
  logic [pdlr_pkg::IDX_W-1:0]           channel_index;
  logic signed [pdlr_pkg::SAMPLE_W-1:0] previous_mono;
  logic                                 primed;
  logic [pdlr_pkg::PHASE_W-1:0]         phase;
  logic signed [pdlr_pkg::SAMPLE_W-1:0] mono;
  logic [pdlr_pkg::RES_W-1:0]           n_count;

  logic                                 out_valid;
  logic signed [pdlr_pkg::SAMPLE_W-1:0] out_sample;
  logic                                 out_last;

  logic [pdlr_pkg::CNT_W-1:0]           eff_count;
  logic [pdlr_pkg::CNT_W-1:0]           idx_next;
  logic signed [pdlr_pkg::SUM_W-1:0]    sum_next;
  logic                                 frame_done;
  logic                                 in_accept;
  logic                                 out_free;
  logic                                 out_load;
  logic [pdlr_pkg::PHASE_W-1:0]         phase_adv;
  logic                                 loop_go;
  logic                                 emit_last;

  logic                                 div_start;
  logic                                 div_done;
  logic signed [pdlr_pkg::SAMPLE_W-1:0] div_q;
  logic                                 interp_start;
  logic                                 interp_done;
  logic signed [pdlr_pkg::SAMPLE_W-1:0] interp_value;

  // zero channels means one; clamp above the supported count
  always_comb begin
    if (channel_count == '0) begin
      eff_count = pdlr_pkg::CNT_W'(1);
    end else if (32'(channel_count) > pdlr_pkg::MAX_CHANNELS) begin
      eff_count = pdlr_pkg::CNT_W'(pdlr_pkg::MAX_CHANNELS);
    end else begin
      eff_count = pdlr_pkg::CNT_W'(channel_count);
    end
  end

  assign in_stream.ready = (state == S_IDLE);
  assign in_accept       = in_stream.valid && in_stream.ready;
  assign sum_next        = frame_sum + pdlr_pkg::SUM_W'(in_stream.sample_in);
  assign idx_next        = pdlr_pkg::CNT_W'(channel_index) + pdlr_pkg::CNT_W'(1);
  // a count lowered mid-frame closes the frame once the index reaches or passes it
  assign frame_done      = idx_next >= eff_count;
  assign div_start       = in_accept && frame_done;

  assign out_free        = !out_valid || out_stream.ready;
  // load the output register from pass-through or interpolation once it is free
  assign out_load        = out_free && ((state == S_PASS) || (state == S_EMIT));
  assign phase_adv       = phase + pdlr_pkg::PHASE_W'(phase_step);
  assign loop_go         = (phase < pdlr_pkg::PHASE_ONE) &&
                           (n_count < pdlr_pkg::RES_W'(pdlr_pkg::MAX_RESULTS));
  // the result is last when the next loop test would fail
  assign emit_last       = (phase_adv >= pdlr_pkg::PHASE_ONE) ||
                           (n_count == pdlr_pkg::RES_W'(pdlr_pkg::MAX_RESULTS - 1));
  assign interp_start    = (state == S_CHECK) && loop_go;

  assign out_stream.valid       = out_valid;
  assign out_stream.sample_out  = out_sample;
  assign out_stream.last_of_run = out_last;

  pdlr_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum_next),
    .divisor  (eff_count),
    .done     (div_done),
    .quotient (div_q)
  );

  pdlr_interp u_interp (
    .clk   (clk),
    .rst   (rst),
    .start (interp_start),
    .prev  (previous_mono),
    .next  (mono),
    .ph    (phase[pdlr_pkg::FRAC_BITS-1:0]),
    .done  (interp_done),
    .value (interp_value)
  );

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count   <= pdlr_pkg::CHAN_W'(1);
      resample_enable <= 1'b0;
      phase_step      <= pdlr_pkg::STEP_ONE;
    end else if (wr_en) begin
      case (wr_index)
        pdlr_pkg::REG_CHANNEL_COUNT:   channel_count   <= wr_data[pdlr_pkg::CHAN_W-1:0];
        pdlr_pkg::REG_RESAMPLE_ENABLE: resample_enable <= wr_data[0];
        pdlr_pkg::REG_PHASE_STEP:      phase_step      <= wr_data[pdlr_pkg::STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // sequencer, block state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      frame_sum     <= '0;
      channel_index <= '0;
      previous_mono <= '0;
      primed        <= 1'b0;
      phase         <= '0;
      out_valid     <= 1'b0;
    end else begin
      // hold a stalled result, drop it once taken
      out_valid <= out_load || (out_valid && !out_stream.ready);
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            // a frame closed by the chunk-end sample is kept; a partial one is dropped
            if (frame_done || in_stream.chunk_end) begin
              frame_sum     <= '0;
              channel_index <= '0;
            end else begin
              frame_sum     <= sum_next;
              channel_index <= idx_next[pdlr_pkg::IDX_W-1:0];
            end
            if (frame_done) begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            mono  <= div_q;
            state <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          n_count <= '0;
          if (!resample_enable) begin
            state <= S_PASS;
          end else if (!primed) begin
            // first mono sample only seeds the interpolator
            primed        <= 1'b1;
            previous_mono <= mono;
            state         <= S_IDLE;
          end else begin
            state <= S_CHECK;
          end
        end
        S_PASS: begin
          if (out_free) begin
            out_sample <= mono;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_CHECK: begin
          state <= loop_go ? S_INTERP : S_FINISH;
        end
        S_INTERP: begin
          if (interp_done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_sample <= interp_value;
            out_last   <= emit_last;
            phase      <= phase_adv;
            n_count    <= n_count + pdlr_pkg::RES_W'(1);
            state      <= emit_last ? S_FINISH : S_CHECK;
          end
        end
        S_FINISH: begin
          // take one sample period off; a run cut by the result cap restarts at zero
          phase         <= (phase >= pdlr_pkg::PHASE_ONE) ? (phase - pdlr_pkg::PHASE_ONE) : '0;
          previous_mono <= mono;
          state         <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* rtl/pdlr_div.sv */
// Bit-serial restoring divider: frame sum by channel count, truncated toward zero.
module pdlr_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [pdlr_pkg::SUM_W-1:0]    dividend,
  input  logic [pdlr_pkg::CNT_W-1:0]           divisor,
  output logic                                 done,
  output logic signed [pdlr_pkg::SAMPLE_W-1:0] quotient
);

  logic                            busy;
  logic                            neg;
  logic [pdlr_pkg::SUM_W-1:0]      quo;
  logic [pdlr_pkg::CNT_W-1:0]      rem;
  logic [pdlr_pkg::CNT_W-1:0]      dvs;
  logic [pdlr_pkg::DIV_CNT_W-1:0]  cnt;
  logic [pdlr_pkg::CNT_W:0]        rem_shift;
  logic                            fits;
  logic [pdlr_pkg::CNT_W:0]        rem_sub;
  logic [pdlr_pkg::SUM_W-1:0]      quo_signed;
  logic                            last_bit;

  assign rem_shift  = {rem, quo[pdlr_pkg::SUM_W-1]};
  assign fits       = rem_shift >= {1'b0, dvs};
  assign rem_sub    = rem_shift - {1'b0, dvs};
  assign quo_signed = neg ? (~quo + pdlr_pkg::SUM_W'(1)) : quo;
  assign quotient   = quo_signed[pdlr_pkg::SAMPLE_W-1:0];
  assign last_bit   = busy && !start &&
                      (cnt == pdlr_pkg::DIV_CNT_W'(pdlr_pkg::SUM_W - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= last_bit;
      if (start) begin
        // load the magnitude and keep the sign aside
        busy <= 1'b1;
        neg  <= dividend[pdlr_pkg::SUM_W-1];
        quo  <= dividend[pdlr_pkg::SUM_W-1] ? (~dividend + pdlr_pkg::SUM_W'(1)) : dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= '0;
      end else if (busy) begin
        rem <= fits ? rem_sub[pdlr_pkg::CNT_W-1:0] : rem_shift[pdlr_pkg::CNT_W-1:0];
        quo <= {quo[pdlr_pkg::SUM_W-2:0], fits};
        cnt <= cnt + pdlr_pkg::DIV_CNT_W'(1);
        if (last_bit) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

/* rtl/pdlr_interp.sv */
// Shared interpolation unit: prev + (next - prev) * phase, rounded half away from zero.
module pdlr_interp (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [pdlr_pkg::SAMPLE_W-1:0]  prev,
  input  logic signed [pdlr_pkg::SAMPLE_W-1:0]  next,
  input  logic [pdlr_pkg::FRAC_BITS-1:0]        ph,
  output logic                                  done,
  output logic signed [pdlr_pkg::SAMPLE_W-1:0]  value
);

  localparam int DIFF_W = pdlr_pkg::SAMPLE_W + 1;
  localparam int PROD_W = DIFF_W + pdlr_pkg::FRAC_BITS + 1;
  localparam int N_W    = PROD_W + 1;
  localparam logic [N_W-1:0] HALF = N_W'(1) << (pdlr_pkg::FRAC_BITS - 1);

  logic [3:0]                            stg;
  logic signed [DIFF_W-1:0]              diff;
  logic [pdlr_pkg::FRAC_BITS-1:0]        ph_r;
  logic signed [pdlr_pkg::SAMPLE_W-1:0]  prev_r;
  logic signed [PROD_W-1:0]              prod;
  logic signed [N_W-1:0]                 acc;
  logic                                  neg;
  logic [N_W-1:0]                        rmag;
  logic [N_W-1:0]                        shifted;
  logic [N_W-1:0]                        rounded;

  assign shifted = rmag >> pdlr_pkg::FRAC_BITS;
  assign rounded = neg ? (~shifted + N_W'(1)) : shifted;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg  <= '0;
      done <= 1'b0;
    end else begin
      stg  <= {stg[2:0], start};
      done <= stg[3];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      diff   <= DIFF_W'(next) - DIFF_W'(prev);
      ph_r   <= ph;
      prev_r <= prev;
    end
    if (stg[0]) begin
      prod <= diff * $signed({1'b0, ph_r});
    end
    if (stg[1]) begin
      acc <= (N_W'(prev_r) <<< pdlr_pkg::FRAC_BITS) + N_W'(prod);
    end
    if (stg[2]) begin
      // round on the magnitude so halves move away from zero
      neg  <= acc[N_W-1];
      rmag <= (acc[N_W-1] ? (~acc + N_W'(1)) : acc) + HALF;
    end
    if (stg[3]) begin
      value <= rounded[pdlr_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

/* rtl/pdlr_checker.sv */
// Port-level checks on the downmix resampler, bound to the top level.
module pdlr_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic [pdlr_pkg::SAMPLE_W-1:0]      sample_out,
  input logic                               last_of_run
);

  // reset leaves the block ready with nothing pending
  a_reset_idle: assert property (@(posedge clk)
    rst |=> in_ready && !out_valid)
    else $error("block not idle after reset");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_out) && $stable(last_of_run))
    else $error("stalled result changed");

  // a run is still in progress after any result that is not its last
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_of_run |=> !in_ready)
    else $error("input taken in the middle of a result run");

endmodule

bind pcm_downmix_linear_resampler pdlr_checker u_pdlr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_stream.ready),
  .out_valid   (out_stream.valid),
  .out_ready   (out_stream.ready),
  .sample_out  (out_stream.sample_out),
  .last_of_run (out_stream.last_of_run)
);
